### src/trf_pkg.sv
// shared types, constants and codes for the tandem repeat finder
package trf_pkg;

    // sizing
    localparam int MAX_WINDOW = 32;
    localparam int MAX_PERIOD = 16;
    localparam int POS_BITS   = 32;
    localparam int BASE_W     = 2;
    localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W      = $clog2(MAX_WINDOW);
    localparam int PER_W      = 5;
    localparam int MOTIF_W    = BASE_W * MAX_PERIOD;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // action codes
    localparam logic [1:0] ACT_BASE    = 2'd0;
    localparam logic [1:0] ACT_UNKNOWN = 2'd1;
    localparam logic [1:0] ACT_FLUSH   = 2'd2;
    localparam logic [1:0] ACT_NONE    = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_MOTIF  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MOTIF  = 2'd2;

    // register reset values
    localparam logic [WIN_W-1:0] WINDOW_LEN_RST = 6'd12;
    localparam logic [PER_W-1:0] MIN_MOTIF_RST  = 5'd1;
    localparam logic [PER_W-1:0] MAX_MOTIF_RST  = 5'd6;

    typedef struct packed {
        logic [1:0]        action;
        logic [BASE_W-1:0] base;
    } in_beat_t;

    typedef struct packed {
        logic [POS_BITS-1:0] repeat_start;
        logic [POS_BITS-1:0] repeat_end;
        logic [POS_BITS-1:0] repeat_length;
        logic [PER_W-1:0]    period;
        logic [MOTIF_W-1:0]  motif_bases;
    } out_beat_t;

    // control shared by every cell of the row
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

### src/trf_cell.sv
// one window cell: holds a base and compares it with the bases further along
module trf_cell (
    input  logic                                          aclk,
    input  trf_pkg::cell_ctrl_t                           ctrl,
    input  logic [trf_pkg::BASE_W-1:0]                    base_in,
    input  logic [trf_pkg::MAX_PERIOD-1:0][trf_pkg::BASE_W-1:0] ahead,
    input  logic [trf_pkg::IDX_W-1:0]                     cell_idx,
    input  logic [trf_pkg::WIN_W-1:0]                     win_len,
    output logic [trf_pkg::BASE_W-1:0]                    base_out,
    output logic [trf_pkg::MAX_PERIOD-1:0]                match
);

    logic [trf_pkg::BASE_W-1:0] base_reg;
    logic [trf_pkg::BASE_W-1:0] base_next;

    // shift from the neighbour or clear on an unknown base or a sequence flush
    always_comb begin
        base_next = base_reg;
        if (ctrl.clear) begin
            base_next = '0;
        end else if (ctrl.shift) begin
            base_next = base_in;
        end
    end

    always_ff @(posedge aclk) begin
        base_reg <= base_next;
    end

    assign base_out = base_reg;

    // match per lag, comparisons reaching past the window always pass
    always_comb begin
        logic [trf_pkg::WIN_W:0] reach;
        reach = '0;
        for (int k = 0; k < trf_pkg::MAX_PERIOD; k++) begin
            reach = (trf_pkg::WIN_W+1)'(cell_idx) + (trf_pkg::WIN_W+1)'(k + 1);
            match[k] = (base_reg == ahead[k]) || (reach >= (trf_pkg::WIN_W+1)'(win_len));
        end
    end

endmodule

### src/trf_cell_row.sv
// chain of window cells with the per-period reduction across the row
module trf_cell_row (
    input  logic                                               aclk,
    input  trf_pkg::cell_ctrl_t                                ctrl,
    input  logic [trf_pkg::BASE_W-1:0]                         base_in,
    input  logic [trf_pkg::WIN_W-1:0]                          win_len,
    output logic [trf_pkg::MAX_PERIOD-1:0]                     per_ok,
    output logic [trf_pkg::MAX_WINDOW-1:0][trf_pkg::BASE_W-1:0] win
);

    logic [trf_pkg::MAX_WINDOW-1:0][trf_pkg::MAX_PERIOD-1:0][trf_pkg::BASE_W-1:0] ahead_w;
    logic [trf_pkg::MAX_WINDOW-1:0][trf_pkg::MAX_PERIOD-1:0] match_w;
    logic [trf_pkg::MAX_WINDOW-1:0][trf_pkg::BASE_W-1:0] feed_w;

    // newest base enters cell 0, each cell passes its base on
    generate
        for (genvar i = 0; i < trf_pkg::MAX_WINDOW; i++) begin : g_cell
            if (i == 0) begin : g_head
                assign feed_w[i] = base_in;
            end else begin : g_body
                assign feed_w[i] = win[i-1];
            end

            for (genvar k = 0; k < trf_pkg::MAX_PERIOD; k++) begin : g_lag
                if (i + k + 1 < trf_pkg::MAX_WINDOW) begin : g_in
                    assign ahead_w[i][k] = win[i+k+1];
                end else begin : g_out
                    assign ahead_w[i][k] = '0;
                end
            end

            trf_cell u_cell (
                .aclk     (aclk),
                .ctrl     (ctrl),
                .base_in  (feed_w[i]),
                .ahead    (ahead_w[i]),
                .cell_idx (trf_pkg::IDX_W'(i)),
                .win_len  (win_len),
                .base_out (win[i]),
                .match    (match_w[i])
            );
        end
    endgenerate

    // a period holds when every cell agrees and it is shorter than the window
    always_comb begin
        logic acc;
        acc = 1'b1;
        for (int k = 0; k < trf_pkg::MAX_PERIOD; k++) begin
            acc = 1'b1;
            for (int i = 0; i < trf_pkg::MAX_WINDOW; i++) begin
                acc = acc & match_w[i][k];
            end
            per_ok[k] = acc && ((trf_pkg::WIN_W+1)'(k + 1) < (trf_pkg::WIN_W+1)'(win_len));
        end
    end

endmodule

### src/tandem_repeat_finder.sv
// a result beat leaves m_ from the result register once the beat that closes the run has passed the check stage
// throughput: one input beat per cycle while m_ready is high; a stalled result stops s_ready
// the rate is set by the combinational period check across the cell row
// reset (aresetn low, synchronous): window empty, position zero, no open run,
// registers back to window_len 12, min_motif 1, max_motif 6
module tandem_repeat_finder (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  trf_pkg::in_beat_t                  s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output trf_pkg::out_beat_t                 m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [trf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [trf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // configuration
    logic [trf_pkg::WIN_W-1:0] win_len_reg, win_len_next;
    logic [trf_pkg::PER_W-1:0] min_motif_reg, min_motif_next;
    logic [trf_pkg::PER_W-1:0] max_motif_reg, max_motif_next;

    // input side state
    logic [trf_pkg::WIN_W-1:0]    valid_reg, valid_next;
    logic [trf_pkg::POS_BITS-1:0] pos_reg, pos_next;

    // check stage
    logic                         s1_valid_reg, s1_valid_next;
    logic [1:0]                   s1_act_reg, s1_act_next;
    logic [trf_pkg::POS_BITS-1:0] s1_end_reg, s1_end_next;

    // open run
    logic                         run_open_reg, run_open_next;
    logic [trf_pkg::POS_BITS-1:0] run_start_reg, run_start_next;
    logic [trf_pkg::PER_W-1:0]    run_period_reg, run_period_next;
    logic [trf_pkg::MOTIF_W-1:0]  run_motif_reg, run_motif_next;

    // result register
    logic                         m_valid_reg, m_valid_next;
    trf_pkg::out_beat_t           m_data_reg, m_data_next;

    logic                         s_acc;
    logic                         s1_go;
    logic                         out_free;
    logic                         emit;
    logic                         open_run;
    trf_pkg::cell_ctrl_t          cell_ctrl;
    logic [trf_pkg::WIN_W-1:0]    len_eff;
    logic [trf_pkg::PER_W-1:0]    lo, hi;
    logic [trf_pkg::MAX_PERIOD-1:0] per_ok, rep_mask, low_mask;
    logic [trf_pkg::MAX_WINDOW-1:0][trf_pkg::BASE_W-1:0] win;
    logic                         rep, atomic_ok, full;
    logic [trf_pkg::PER_W-1:0]    first_k;
    logic [trf_pkg::MOTIF_W-1:0]  motif;
    logic [trf_pkg::POS_BITS-1:0] start_pos;

    // handshakes
    assign out_free  = !m_valid_reg || m_ready;
    assign s1_go     = s1_valid_reg && out_free;
    assign s_ready   = !s1_valid_reg || s1_go;
    assign s_acc     = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // configuration writes
    always_comb begin
        win_len_next   = win_len_reg;
        min_motif_next = min_motif_reg;
        max_motif_next = max_motif_reg;
        if (cfg_valid) begin
            case (cfg_index)
                trf_pkg::REG_WINDOW_LEN: win_len_next = cfg_data[trf_pkg::WIN_W-1:0];
                trf_pkg::REG_MIN_MOTIF:  min_motif_next = cfg_data[trf_pkg::PER_W-1:0];
                trf_pkg::REG_MAX_MOTIF:  max_motif_next = cfg_data[trf_pkg::PER_W-1:0];
                default: ;
            endcase
        end
    end

    // effective window length and period range
    always_comb begin
        len_eff = win_len_reg;
        if (win_len_reg < trf_pkg::WIN_W'(2)) begin
            len_eff = trf_pkg::WIN_W'(2);
        end else if (win_len_reg > trf_pkg::WIN_W'(trf_pkg::MAX_WINDOW)) begin
            len_eff = trf_pkg::WIN_W'(trf_pkg::MAX_WINDOW);
        end
        lo = (min_motif_reg == '0) ? trf_pkg::PER_W'(1) : min_motif_reg;
        hi = (max_motif_reg > trf_pkg::PER_W'(trf_pkg::MAX_PERIOD)) ?
             trf_pkg::PER_W'(trf_pkg::MAX_PERIOD) : max_motif_reg;
    end

    // cell row control from the accepted beat
    always_comb begin
        cell_ctrl.shift = s_acc && (s_data.action == trf_pkg::ACT_BASE);
        cell_ctrl.clear = s_acc && ((s_data.action == trf_pkg::ACT_UNKNOWN) ||
                                    (s_data.action == trf_pkg::ACT_FLUSH));
    end

    trf_cell_row u_row (
        .aclk    (aclk),
        .ctrl    (cell_ctrl),
        .base_in (s_data.base),
        .win_len (len_eff),
        .per_ok  (per_ok),
        .win     (win)
    );

    // position, fill count and check stage load
    always_comb begin
        valid_next    = valid_reg;
        pos_next      = pos_reg;
        s1_act_next   = s1_act_reg;
        s1_end_next   = s1_end_reg;
        s1_valid_next = s1_go ? 1'b0 : s1_valid_reg;
        if (s_acc) begin
            case (s_data.action)
                trf_pkg::ACT_BASE: begin
                    pos_next = pos_reg + trf_pkg::POS_BITS'(1);
                    if (valid_reg != trf_pkg::WIN_W'(trf_pkg::MAX_WINDOW)) begin
                        valid_next = valid_reg + trf_pkg::WIN_W'(1);
                    end
                    s1_valid_next = 1'b1;
                end
                trf_pkg::ACT_UNKNOWN: begin
                    pos_next      = pos_reg + trf_pkg::POS_BITS'(1);
                    valid_next    = '0;
                    s1_valid_next = 1'b1;
                end
                trf_pkg::ACT_FLUSH: begin
                    pos_next      = '0;
                    valid_next    = '0;
                    s1_valid_next = 1'b1;
                end
                default: ;
            endcase
            s1_act_next = s_data.action;
            s1_end_next = pos_reg;
        end
    end

    // period search: first period in range and the atomicity test
    always_comb begin
        for (int k = 0; k < trf_pkg::MAX_PERIOD; k++) begin
            rep_mask[k] = per_ok[k] && (trf_pkg::PER_W'(k + 1) >= lo) &&
                          (trf_pkg::PER_W'(k + 1) <= hi);
            low_mask[k] = trf_pkg::PER_W'(k + 1) < lo;
        end
        rep       = |rep_mask;
        atomic_ok = !(|(per_ok & low_mask));
        full      = valid_reg >= len_eff;
        first_k   = trf_pkg::PER_W'(1);
        for (int k = trf_pkg::MAX_PERIOD - 1; k >= 0; k--) begin
            if (rep_mask[k]) begin
                first_k = trf_pkg::PER_W'(k + 1);
            end
        end
    end

    // motif: oldest first_k bases of the window, oldest in the top used pair
    always_comb begin
        logic [trf_pkg::WIN_W:0] src;
        src = '0;
        for (int j = 0; j < trf_pkg::MAX_PERIOD; j++) begin
            src = (trf_pkg::WIN_W+1)'(len_eff) - (trf_pkg::WIN_W+1)'(first_k) +
                  (trf_pkg::WIN_W+1)'(j);
            if ((trf_pkg::PER_W'(j) < first_k) &&
                (src < (trf_pkg::WIN_W+1)'(trf_pkg::MAX_WINDOW))) begin
                motif[j*trf_pkg::BASE_W +: trf_pkg::BASE_W] = win[src[trf_pkg::IDX_W-1:0]];
            end else begin
                motif[j*trf_pkg::BASE_W +: trf_pkg::BASE_W] = '0;
            end
        end
        start_pos = pos_reg - trf_pkg::POS_BITS'(len_eff);
    end

    // run open and close decisions
    always_comb begin
        emit     = 1'b0;
        open_run = 1'b0;
        if (s1_go) begin
            case (s1_act_reg)
                trf_pkg::ACT_BASE: begin
                    if (full) begin
                        if (rep) begin
                            open_run = !run_open_reg && atomic_ok;
                        end else begin
                            emit = run_open_reg;
                        end
                    end
                end
                trf_pkg::ACT_UNKNOWN, trf_pkg::ACT_FLUSH: begin
                    emit = run_open_reg;
                end
                default: ;
            endcase
        end
    end

    // run state and result register
    always_comb begin
        run_open_next   = run_open_reg;
        run_start_next  = run_start_reg;
        run_period_next = run_period_reg;
        run_motif_next  = run_motif_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        if (open_run) begin
            run_open_next   = 1'b1;
            run_start_next  = start_pos;
            run_period_next = first_k;
            run_motif_next  = motif;
        end
        if (emit) begin
            run_open_next             = 1'b0;
            m_valid_next              = 1'b1;
            m_data_next.repeat_start  = run_start_reg;
            m_data_next.repeat_end    = s1_end_reg;
            m_data_next.repeat_length = s1_end_reg - run_start_reg;
            m_data_next.period        = run_period_reg;
            m_data_next.motif_bases   = run_motif_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_len_reg   <= trf_pkg::WINDOW_LEN_RST;
            min_motif_reg <= trf_pkg::MIN_MOTIF_RST;
            max_motif_reg <= trf_pkg::MAX_MOTIF_RST;
            valid_reg     <= '0;
            pos_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            run_open_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            win_len_reg   <= win_len_next;
            min_motif_reg <= min_motif_next;
            max_motif_reg <= max_motif_next;
            valid_reg     <= valid_next;
            pos_reg       <= pos_next;
            s1_valid_reg  <= s1_valid_next;
            run_open_reg  <= run_open_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        s1_act_reg     <= s1_act_next;
        s1_end_reg     <= s1_end_next;
        run_start_reg  <= run_start_next;
        run_period_reg <= run_period_next;
        run_motif_reg  <= run_motif_next;
        m_data_reg     <= m_data_next;
    end

    // input stalls only behind a check stage that is blocked by a waiting result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled without a blocked result");

    // a result beat is only produced from an open run
    a_emit_open: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> run_open_reg)
        else $error("result produced with no open run");

    // an open run always carries a period in range
    a_period_range: assert property (@(posedge aclk) disable iff (!aresetn)
        run_open_reg |-> ((run_period_reg != '0) &&
                          (run_period_reg <= trf_pkg::PER_W'(trf_pkg::MAX_PERIOD))))
        else $error("open run with period out of range");

    // a sequence boundary returns the position to zero
    a_flush_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && (s_data.action == trf_pkg::ACT_FLUSH)) |=> (pos_reg == '0))
        else $error("position not cleared at sequence boundary");

endmodule
